// ===== rtl/core/obrb_pkg.sv =====
// ----------------------------------------------------------------------------
// obrb_pkg: shared types and constants of the overwriting byte ring buffer
// Buffer depth, pointer and count widths, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package obrb_pkg;

  // Number of byte entries in the ring
  localparam int unsigned Depth   = 32;
  // Index into the ring
  localparam int unsigned PtrW    = $clog2(Depth);
  // Readable count, 0..Depth
  localparam int unsigned CntW    = $clog2(Depth + 1);
  // Width of the fill_count result field
  localparam int unsigned FillW   = 6;
  // Width of the data byte
  localparam int unsigned ByteW   = 8;

  // Input operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ByteW-1:0] byte_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;      // store a byte, load the write result
    logic empty_res;  // load the empty drain result
    logic rd_en;      // read oldest byte, advance read position, drop count
    logic emit;       // load the byte from the last read as a drain result
  } obrb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;   // no readable bytes left
    logic out_free;   // output register can take a result this cycle
  } obrb_sts_t;

endpackage

// ===== rtl/core/obrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// obrb_ctrl: controller of the overwriting byte ring buffer
// Takes input transfers, steps a drain through the ring one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module obrb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  obrb_pkg::obrb_sts_t sts_i,
  output obrb_pkg::obrb_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;
  logic accept;

  // Input is taken only in idle and when the output register can load
  assign in_stall_o = (state_q != StIdle) || !sts_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (op_i == obrb_pkg::OpWrite) begin
            cmd_o.wr_en = 1'b1;
          end else if (sts_i.cnt_zero) begin
            cmd_o.empty_res = 1'b1;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = StEmit;
          end
        end
      end
      StEmit: begin
        // emit the fetched byte and fetch the next one in the same cycle
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.cnt_zero) begin
            state_d = StIdle;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/obrb_dp.sv =====
// ----------------------------------------------------------------------------
// obrb_dp: datapath of the overwriting byte ring buffer
// Byte memory, read position, readable count and the output register.
// ----------------------------------------------------------------------------
module obrb_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_i,
  input  obrb_pkg::obrb_cmd_t   cmd_i,
  output obrb_pkg::obrb_sts_t   sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            byte_out_o,
  output logic                  has_data_o,
  output logic                  last_o,
  output logic [5:0]            fill_count_o
);

  obrb_pkg::byte_t mem_q [obrb_pkg::Depth];
  obrb_pkg::byte_t rd_data_q;
  obrb_pkg::ptr_t  rd_pos_q, rd_pos_d, rd_pos_inc, wr_pos;
  obrb_pkg::cnt_t  cnt_q, cnt_d, cnt_after_wr;
  logic [obrb_pkg::PtrW:0] wr_sum;
  logic            full;

  logic                           out_valid_q, out_valid_d;
  obrb_pkg::byte_t                out_byte_q, out_byte_d;
  logic                           out_has_q, out_has_d;
  logic                           out_last_q, out_last_d;
  logic [obrb_pkg::FillW-1:0]     out_fill_q, out_fill_d;
  logic                           out_load;

  assign full = (cnt_q == obrb_pkg::CntW'(obrb_pkg::Depth));

  // Position arithmetic, wrapping modulo the depth
  assign rd_pos_inc = (rd_pos_q == obrb_pkg::PtrW'(obrb_pkg::Depth - 1)) ?
                      '0 : rd_pos_q + 1'b1;
  assign wr_sum     = (obrb_pkg::PtrW+1)'(rd_pos_q) + (obrb_pkg::PtrW+1)'(cnt_q);
  assign wr_pos     = (wr_sum >= (obrb_pkg::PtrW+1)'(obrb_pkg::Depth)) ?
                      obrb_pkg::PtrW'(wr_sum - (obrb_pkg::PtrW+1)'(obrb_pkg::Depth)) :
                      obrb_pkg::PtrW'(wr_sum);
  assign cnt_after_wr = full ? cnt_q : cnt_q + 1'b1;

  // Read position and count update
  always_comb begin
    rd_pos_d = rd_pos_q;
    cnt_d    = cnt_q;
    if (cmd_i.wr_en) begin
      cnt_d = cnt_after_wr;
      if (full) begin
        rd_pos_d = rd_pos_inc;
      end
    end else if (cmd_i.rd_en) begin
      rd_pos_d = rd_pos_inc;
      cnt_d    = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pos_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_pos_q <= rd_pos_d;
      cnt_q    <= cnt_d;
    end
  end

  // Byte memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_pos] <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_pos_q];
    end
  end

  // Output register; count after a drained byte is the count already lowered
  assign out_load = cmd_i.wr_en || cmd_i.empty_res || cmd_i.emit;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    out_fill_d  = out_fill_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b1;
      out_byte_d  = '0;
      out_has_d   = 1'b0;
      out_fill_d  = '0;
      if (cmd_i.wr_en) begin
        out_fill_d = obrb_pkg::FillW'(cnt_after_wr);
      end else if (cmd_i.emit) begin
        out_byte_d = rd_data_q;
        out_has_d  = 1'b1;
        out_last_d = (cnt_q == '0);
        out_fill_d = obrb_pkg::FillW'(cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_fill_q <= out_fill_d;
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign byte_out_o   = out_byte_q;
  assign has_data_o   = out_has_q;
  assign last_o       = out_last_q;
  assign fill_count_o = out_fill_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= obrb_pkg::CntW'(obrb_pkg::Depth))
    else $error("readable count above depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register loaded while holding a stalled result");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.wr_en, cmd_i.empty_res, cmd_i.emit}))
    else $error("more than one result source in a cycle");

  a_rd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (cnt_q != '0) && !cmd_i.wr_en)
    else $error("read from an empty ring");

endmodule

// ===== rtl/core/overwriting_byte_ring_buffer_top.sv =====
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_top: byte ring buffer that drops its oldest byte
// Controller plus datapath; holds the newest 32 bytes, drains them in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, op_i, data_i): op_i low writes
//   data_i behind the newest byte; when the ring is full the oldest byte is
//   dropped. op_i high drains every readable byte, oldest first.
//   Output channel (out_valid_o / out_stall_i): a write gives one result with
//   has_data_o low, last_o high and the new fill count. A drain of n bytes
//   gives n results with has_data_o high, fill_count_o counting down to 0 and
//   last_o on the final one; a drain of an empty ring gives one result with
//   has_data_o low and last_o high.
//   A result appears in the cycle after its input transfer; a drained byte
//   first passes through the registered memory read.
//   Throughput: writes run at one per cycle while the output is not stalled.
//   A drain gives one byte per cycle from the single memory read port when
//   the output is not stalled, and blocks new input until its last byte is loaded.
//   Reset empties the ring and clears the output valid flag. A stalled receiver
//   holds the current result and stalls the input side and the drain.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       has_data_o,
  output logic       last_o,
  output logic [5:0] fill_count_o
);

  obrb_pkg::obrb_cmd_t cmd;
  obrb_pkg::obrb_sts_t sts;

  // Sequencing of transfers and drains
  obrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, pointers and output register
  obrb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_i       (data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_out_o   (byte_out_o),
    .has_data_o   (has_data_o),
    .last_o       (last_o),
    .fill_count_o (fill_count_o)
  );

endmodule
